// ===== rtl/mmp_pkg.sv =====
// shared constants, types and helpers of the modular matrix power unit
// used by the interfaces, the controller, the datapath and the top level
`default_nettype none

package mmp_pkg;

    localparam int REG_W = 30;
    localparam int CNT_W = 63;
    localparam int IDX_W = 3;
    localparam int PROD_W = 2 * REG_W;

    localparam logic [REG_W-1:0] PRIME  = 30'd1000000007;
    // 2^30 mod prime, used to fold the upper half of a product down
    localparam logic [REG_W-1:0] FOLD_C = 30'd73741817;

    localparam logic [IDX_W-1:0] REG_MAT_00  = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAT_01  = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAT_10  = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAT_11  = 3'd3;
    localparam logic [IDX_W-1:0] REG_START_0 = 3'd4;
    localparam logic [IDX_W-1:0] REG_START_1 = 3'd5;

    localparam logic [REG_W-1:0] RST_MAT_00  = 30'd3;
    localparam logic [REG_W-1:0] RST_MAT_01  = 30'd2;
    localparam logic [REG_W-1:0] RST_MAT_10  = 30'd2;
    localparam logic [REG_W-1:0] RST_MAT_11  = 30'd2;
    localparam logic [REG_W-1:0] RST_START_0 = 30'd6;
    localparam logic [REG_W-1:0] RST_START_1 = 30'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        MODE_ACC,
        MODE_SQR,
        MODE_VEC
    } t_mode;

    typedef struct packed {
        logic       load;
        logic       mul_go;
        t_mode      mode;
        logic [2:0] k;
        logic       tmp_wr;
        logic       commit;
        logic       sum_clr;
        logic       e_shift;
        logic       out_load;
        logic       out_zero;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic e_zero;
        logic e_lsb;
        logic mul_done;
        logic out_full;
    } t_dp_sts;

    // one conditional subtract: valid for any value below twice the prime
    function automatic logic [REG_W-1:0] mod_reduce(input logic [REG_W-1:0] v);
        mod_reduce = (v >= PRIME) ? (v - PRIME) : v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mmp_if.sv =====
// valid/ready channel interfaces of the modular matrix power unit
// depends on mmp_pkg for field widths
`default_nettype none

interface mmp_count_if import mmp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] count;
    modport source (output valid, output count, input ready);
    modport sink   (input valid, input count, output ready);
endinterface

interface mmp_answer_if import mmp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REG_W-1:0] answer;
    modport source (output valid, output answer, input ready);
    modport sink   (input valid, input answer, output ready);
endinterface

interface mmp_cfg_if import mmp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [REG_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/modular_matrix_power_2x2_unit.sv =====
// top level of the modular matrix power unit: controller plus datapath
// depends on mmp_pkg, mmp_if, mmp_ctrl and mmp_dp
//
// usage:
// - i_count carries n; one answer per count leaves on o_answer, equal to the
//   sum of the entries of M^(n-1) * start vector modulo 1000000007
// - i_cfg writes the six registers (matrix row-major, then start vector);
//   it is always ready, indexes beyond the list are dropped; write only
//   while the unit is idle
// - one count is worked on at a time; i_count is ready only in the idle state
// - each modular product runs on the single shared 30x30 multiplier (one
//   multiply, folds of the upper half until it is zero, one accumulate); a
//   matrix step is eight products, and a count takes L + W steps, L the bit
//   length of n-1 and W its set bits, then four products for the vector;
//   n of 0 skips the products
// - the answer sits in an output register; the next count is taken while
//   it waits, and a finished answer holds in the controller until the
//   register is free, so a stalled receiver stalls only at that point
// - reset (synchronous, active low) restores the register reset values and
//   drops any work and any pending answer
`default_nettype none

module modular_matrix_power_2x2_unit import mmp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mmp_count_if.sink   i_count,
    mmp_answer_if.source o_answer,
    mmp_cfg_if.sink     i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    // configuration transfers are taken every cycle
    assign i_cfg.ready   = 1'b1;
    assign i_count.ready = in_ready;

    // sequencer: exponent bits, matrix steps, final vector product
    mmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_count.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // registers, shared modular multiplier and output register
    mmp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_count     (i_count.count),
        .i_cfg_wr    (i_cfg.valid),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_answer.ready),
        .o_out_valid (o_answer.valid),
        .o_answer    (o_answer.answer)
    );

endmodule

`default_nettype wire

// ===== rtl/mmp_ctrl.sv =====
// sequencer of the modular matrix power unit: walks the exponent bits and
// the modular products of each matrix step; depends on mmp_pkg
`default_nettype none

module mmp_ctrl import mmp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state     r_state, n_state;
    t_mode      r_mode, n_mode;
    logic [2:0] r_k, n_k;
    logic       r_zero, n_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MODE_SQR;
            r_k     <= '0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_k     <= n_k;
            r_zero  <= n_zero;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_k        = r_k;
        n_zero     = r_zero;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mode = r_mode;
        o_cmd.k    = r_k;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_zero     = i_sts.count_zero;
                    n_state    = i_sts.count_zero ? ST_FINISH : ST_BIT;
                end
            end
            ST_BIT: begin
                o_cmd.sum_clr = 1'b1;
                n_k           = '0;
                n_state       = ST_MUL_GO;
                if (i_sts.e_zero) begin
                    n_mode = MODE_VEC;
                end else begin
                    n_mode = i_sts.e_lsb ? MODE_ACC : MODE_SQR;
                end
            end
            ST_MUL_GO: begin
                o_cmd.mul_go = 1'b1;
                n_state      = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (i_sts.mul_done) begin
                    if (r_mode == MODE_VEC) begin
                        if (r_k == 3'd3) begin
                            n_state = ST_FINISH;
                        end else begin
                            n_k     = r_k + 3'd1;
                            n_state = ST_MUL_GO;
                        end
                    end else begin
                        if (r_k[0]) begin
                            o_cmd.tmp_wr  = 1'b1;
                            o_cmd.sum_clr = 1'b1;
                        end
                        if (r_k == 3'd7) begin
                            o_cmd.commit = 1'b1;
                            n_k          = '0;
                            if (r_mode == MODE_ACC) begin
                                n_mode  = MODE_SQR;
                                n_state = ST_MUL_GO;
                            end else begin
                                o_cmd.e_shift = 1'b1;
                                n_state       = ST_BIT;
                            end
                        end else begin
                            n_k     = r_k + 3'd1;
                            n_state = ST_MUL_GO;
                        end
                    end
                end
            end
            ST_FINISH: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_zero = r_zero;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mmp_dp.sv =====
// datapath of the modular matrix power unit: configuration registers, matrix
// and vector registers, one shared modular multiplier, output register; uses mmp_pkg
`default_nettype none

module mmp_dp import mmp_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_sts               o_sts,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire logic             i_cfg_wr,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [REG_W-1:0] i_cfg_data,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output logic [REG_W-1:0]      o_answer
);

    function automatic logic [REG_W-1:0] pick4(
        input logic [REG_W-1:0] a0, input logic [REG_W-1:0] a1,
        input logic [REG_W-1:0] a2, input logic [REG_W-1:0] a3,
        input logic [1:0] sel);
        logic [REG_W-1:0] v;
        unique case (sel)
            2'd0:    v = a0;
            2'd1:    v = a1;
            2'd2:    v = a2;
            default: v = a3;
        endcase
        pick4 = v;
    endfunction

    // configuration registers
    logic [REG_W-1:0] r_m00, r_m01, r_m10, r_m11, r_st0, r_st1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m00 <= RST_MAT_00;
            r_m01 <= RST_MAT_01;
            r_m10 <= RST_MAT_10;
            r_m11 <= RST_MAT_11;
            r_st0 <= RST_START_0;
            r_st1 <= RST_START_1;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_idx)
                REG_MAT_00:  r_m00 <= i_cfg_data;
                REG_MAT_01:  r_m01 <= i_cfg_data;
                REG_MAT_10:  r_m10 <= i_cfg_data;
                REG_MAT_11:  r_m11 <= i_cfg_data;
                REG_START_0: r_st0 <= i_cfg_data;
                REG_START_1: r_st1 <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // working registers
    logic [REG_W-1:0]  r_b0, r_b1, r_b2, r_b3;
    logic [REG_W-1:0]  r_a0, r_a1, r_a2, r_a3;
    logic [REG_W-1:0]  r_t0, r_t1, r_t2;
    logic [REG_W-1:0]  r_s0, r_s1;
    logic [REG_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_e;
    logic [PROD_W-1:0] r_v;
    logic              r_busy;
    logic              r_out_valid;
    logic [REG_W-1:0]  r_answer;

    // operand selection
    logic [REG_W-1:0] op_x, op_y;
    always_comb begin
        unique case (i_cmd.mode)
            MODE_ACC: begin
                op_x = pick4(r_a0, r_a1, r_a2, r_a3, {i_cmd.k[2], i_cmd.k[0]});
                op_y = pick4(r_b0, r_b1, r_b2, r_b3, {i_cmd.k[0], i_cmd.k[1]});
            end
            MODE_SQR: begin
                op_x = pick4(r_b0, r_b1, r_b2, r_b3, {i_cmd.k[2], i_cmd.k[0]});
                op_y = pick4(r_b0, r_b1, r_b2, r_b3, {i_cmd.k[0], i_cmd.k[1]});
            end
            default: begin
                op_x = pick4(r_a0, r_a1, r_a2, r_a3, i_cmd.k[1:0]);
                op_y = i_cmd.k[0] ? r_s1 : r_s0;
            end
        endcase
    end

    // shared multiplier: first the product, then folding of the upper half
    logic [REG_W-1:0]  hi, lo, mul_a, mul_b, red;
    logic [PROD_W-1:0] product, n_v;
    logic              done;
    logic [REG_W:0]    sum_wide;
    logic [REG_W-1:0]  sum_new;

    assign hi      = r_v[PROD_W-1:REG_W];
    assign lo      = r_v[REG_W-1:0];
    assign mul_a   = r_busy ? hi : op_x;
    assign mul_b   = r_busy ? FOLD_C : op_y;
    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign n_v     = r_busy ? (product + PROD_W'(lo)) : product;
    assign done    = r_busy && (hi == '0);
    assign red     = mod_reduce(lo);
    assign sum_wide = {1'b0, r_sum} + {1'b0, red};
    assign sum_new = (sum_wide >= {1'b0, PRIME}) ? REG_W'(sum_wide - {1'b0, PRIME})
                                                 : sum_wide[REG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.mul_go) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go || (r_busy && !done)) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_b0 <= mod_reduce(r_m00);
            r_b1 <= mod_reduce(r_m01);
            r_b2 <= mod_reduce(r_m10);
            r_b3 <= mod_reduce(r_m11);
            r_a0 <= REG_W'(1);
            r_a1 <= '0;
            r_a2 <= '0;
            r_a3 <= REG_W'(1);
            r_s0 <= mod_reduce(r_st0);
            r_s1 <= mod_reduce(r_st1);
            r_e  <= i_count - CNT_W'(1);
        end else begin
            if (i_cmd.e_shift) begin
                r_e <= r_e >> 1;
            end
            if (i_cmd.tmp_wr) begin
                unique case (i_cmd.k[2:1])
                    2'd0:    r_t0 <= sum_new;
                    2'd1:    r_t1 <= sum_new;
                    2'd2:    r_t2 <= sum_new;
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                if (i_cmd.mode == MODE_ACC) begin
                    r_a0 <= r_t0;
                    r_a1 <= r_t1;
                    r_a2 <= r_t2;
                    r_a3 <= sum_new;
                end else begin
                    r_b0 <= r_t0;
                    r_b1 <= r_t1;
                    r_b2 <= r_t2;
                    r_b3 <= sum_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_clr || i_cmd.load) begin
            r_sum <= '0;
        end else if (done) begin
            r_sum <= sum_new;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_answer <= i_cmd.out_zero ? '0 : r_sum;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_answer         = r_answer;
    assign o_sts.count_zero = (i_count == '0);
    assign o_sts.e_zero     = (r_e == '0);
    assign o_sts.e_lsb      = r_e[0];
    assign o_sts.mul_done   = done;
    assign o_sts.out_full   = r_out_valid && !i_out_ready;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// self-checking testbench of the modular matrix power unit
// depends on mmp_pkg, mmp_if and the rtl of modular_matrix_power_2x2_unit
`default_nettype none

module tb;
    import mmp_pkg::*;

    localparam int N_RANDOM = 800;
    localparam longint CYCLE_LIMIT = 40_000_000;

    logic i_clk;
    logic i_rst_n;

    mmp_count_if  count_ch ();
    mmp_answer_if answer_ch ();
    mmp_cfg_if    cfg_ch ();

    modular_matrix_power_2x2_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_count (count_ch),
        .o_answer(answer_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor copy of the six registers, raw 30-bit values
    logic [REG_W-1:0] shadow_regs [6];

    logic [CNT_W-1:0] pending_counts [$];
    logic [REG_W-1:0] expected_answers [$];
    int mismatches = 0;
    int answers_seen = 0;
    longint cycle_count = 0;
    bit stall_window = 0;   // long receiver hold-off requested

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // modular helpers on 64-bit values, both operands below the prime
    function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b);
        mulmod = (a * b) % PRIME;
    endfunction

    // 2x2 product, row-major
    function automatic void mat_product(input longint unsigned p [4],
                                        input longint unsigned q [4],
                                        output longint unsigned r [4]);
        r[0] = (mulmod(p[0], q[0]) + mulmod(p[1], q[2])) % PRIME;
        r[1] = (mulmod(p[0], q[1]) + mulmod(p[1], q[3])) % PRIME;
        r[2] = (mulmod(p[2], q[0]) + mulmod(p[3], q[2])) % PRIME;
        r[3] = (mulmod(p[2], q[1]) + mulmod(p[3], q[3])) % PRIME;
    endfunction

    // answer for count n under the current shadow registers
    function automatic logic [REG_W-1:0] power_answer(input logic [CNT_W-1:0] n);
        longint unsigned base [4];
        longint unsigned acc [4];
        longint unsigned tmp [4];
        longint unsigned s0, s1, v0, v1;
        logic [CNT_W-1:0] e;
        if (n == 0) return '0;
        for (int i = 0; i < 4; i++) base[i] = shadow_regs[i] % PRIME;
        s0 = shadow_regs[REG_START_0] % PRIME;
        s1 = shadow_regs[REG_START_1] % PRIME;
        acc = '{1, 0, 0, 1};
        e = n - 1;
        while (e != 0) begin
            if (e[0]) begin
                mat_product(acc, base, tmp);
                acc = tmp;
            end
            mat_product(base, base, tmp);
            base = tmp;
            e = e >> 1;
        end
        v0 = (mulmod(acc[0], s0) + mulmod(acc[1], s1)) % PRIME;
        v1 = (mulmod(acc[2], s0) + mulmod(acc[3], s1)) % PRIME;
        return REG_W'((v0 + v1) % PRIME);
    endfunction

    // count driver: pulls from the pending queue, random gap after each item
    bit count_taken = 0;
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            count_ch.valid <= 1'b0;
        end else if (count_ch.valid && !count_taken) begin
            // hold the item until it is taken
        end else if (send_gap > 0) begin
            count_ch.valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_counts.size() > 0) begin
            count_ch.valid <= 1'b1;
            count_ch.count <= pending_counts.pop_front();
            send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        end else begin
            count_ch.valid <= 1'b0;
        end
    end

    // predict on every accepted count transfer
    always @(posedge i_clk) begin
        count_taken <= i_rst_n && count_ch.valid && count_ch.ready;
        if (i_rst_n && count_ch.valid && count_ch.ready)
            expected_answers.push_back(power_answer(count_ch.count));
    end

    // receiver ready: random stalls, plus the long hold-off window
    int recv_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n || stall_window) begin
            answer_ch.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            answer_ch.ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else begin
            answer_ch.ready <= 1'b1;
            if (answer_ch.valid)
                recv_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        end
    end

    // answer monitor
    always @(posedge i_clk) begin
        if (i_rst_n && answer_ch.valid && answer_ch.ready) begin
            answers_seen <= answers_seen + 1;
            if (expected_answers.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected answer transfer %0d", answer_ch.answer);
            end else begin
                logic [REG_W-1:0] want;
                want = expected_answers.pop_front();
                if (want !== answer_ch.answer) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("answer mismatch: expected %0d got %0d",
                                 want, answer_ch.answer);
                end
            end
        end
    end

    // global watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("modular_matrix_power_2x2_unit regression: fail");
            $finish;
        end
    end

    // one register write over the config channel
    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx < 6) shadow_regs[idx] = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // wait until every queued count is answered, then let the block settle
    task automatic drain();
        while (pending_counts.size() > 0 || count_ch.valid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic load_matrix(input logic [REG_W-1:0] m [6]);
        for (int i = 0; i < 6; i++) cfg_write(IDX_W'(i), m[i]);
    endtask

    // mostly short counts keep the run fast; a few span all 63 bits
    function automatic logic [CNT_W-1:0] random_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) return CNT_W'($urandom_range(0, 2));
        if (pick < 75) return CNT_W'($urandom_range(0, 4095));
        if (pick < 92) return CNT_W'({$urandom, $urandom} >> $urandom_range(1, 62));
        return CNT_W'({$urandom, $urandom});
    endfunction

    function automatic logic [REG_W-1:0] random_reg();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return REG_W'(PRIME - 1);
        if (pick == 1) return 30'h3fffffff - REG_W'($urandom_range(0, 3));
        if (pick == 2) return REG_W'($urandom_range(0, 2));
        return REG_W'($urandom);
    endfunction

    initial begin
        logic [REG_W-1:0] setting [6];
        logic [CNT_W-1:0] all_ones;
        i_rst_n = 1'b0;
        count_ch.valid = 1'b0;
        count_ch.count = '0;
        answer_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        shadow_regs = '{RST_MAT_00, RST_MAT_01, RST_MAT_10, RST_MAT_11,
                        RST_START_0, RST_START_1};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero, one, small, bit-walk and extreme counts at reset values
        all_ones = '1;
        pending_counts = '{0, 1, 2, 3, 4, 5, 64, 1 << 20};
        pending_counts.push_back(all_ones);
        pending_counts.push_back(CNT_W'(1) << (CNT_W - 1));
        pending_counts.push_back((CNT_W'(1) << (CNT_W - 1)) + 1);
        pending_counts.push_back(CNT_W'(64'h2aaa_aaaa_aaaa_aaaa));
        pending_counts.push_back(CNT_W'(64'h5555_5555_5555_5555));
        drain();

        // registers at and above the prime, plus two indexes beyond the list
        setting = '{PRIME, REG_W'(PRIME - 1), 30'h3fffffff, REG_W'(PRIME + 1),
                    30'h3fffffff, REG_W'(PRIME - 1)};
        load_matrix(setting);
        cfg_write(3'd6, 30'h1234567);
        cfg_write(3'd7, 30'h3fffffff);
        pending_counts = '{0, 1, 2, 7, 1000};
        pending_counts.push_back(all_ones);
        drain();

        // all zero registers
        setting = '{0, 0, 0, 0, 0, 0};
        load_matrix(setting);
        pending_counts = '{1, 2, 100};
        drain();

        // long receiver hold-off while short counts keep coming
        setting = '{1, 1, 1, 0, 1, 0};
        load_matrix(setting);
        stall_window = 1;
        for (int i = 0; i < 6; i++) pending_counts.push_back(CNT_W'($urandom_range(0, 40)));
        repeat (6000) @(posedge i_clk);
        stall_window = 0;
        drain();

        // random phases, each under a fresh register setting
        for (int phase = 0; phase < 8; phase++) begin
            for (int i = 0; i < 6; i++) setting[i] = random_reg();
            load_matrix(setting);
            for (int i = 0; i < N_RANDOM / 8; i++) pending_counts.push_back(random_count());
            drain();
        end

        $display("covered %0d answers across directed, extreme and random register settings",
                 answers_seen);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("modular_matrix_power_2x2_unit regression: pass");
        else
            $display("modular_matrix_power_2x2_unit regression: fail");
        $finish;
    end
endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/mmp_pkg.sv
rtl/mmp_if.sv
rtl/mmp_ctrl.sv
rtl/mmp_dp.sv
rtl/modular_matrix_power_2x2_unit.sv
test/tb.sv
